// File: rtl/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Concurrent check macros used by the cache top level; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkv: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkv: next-cycle check failed");

`else

`define LKV_ASSERT_IMP(label, clk, rst, ante, cons)
`define LKV_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Sizes, operation codes and shared types of the cache and its cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   // Storage sizes.
   localparam int CAPACITY   = 16;
   localparam int KEY_WIDTH  = 32;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_WIDTH  = $clog2(CAPACITY);
   localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);

   // Fixed port field widths.
   localparam int FUNC_WIDTH  = 2;
   localparam int FIELD_WIDTH = 32;
   localparam int OCC_WIDTH   = 5;
   localparam int CAP_WIDTH   = 5;
   localparam int CAP_RESET   = 16;

   // Operation codes; the fourth code is unused and leaves the cache alone.
   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_GET    = 2'd0,
      FUNC_PUT    = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   // How the cell row moves its entries.
   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_DOWN,
      SHIFT_UP
   } shift_mode_type;

   typedef struct packed {
      shift_mode_type       mode;
      logic [IDX_WIDTH-1:0] pos;
   } shift_cmd_type;

   // One stored entry; position in the row gives its recency.
   typedef struct packed {
      logic                  valid;
      logic [KEY_WIDTH-1:0]  key;
      logic [DATA_WIDTH-1:0] data;
   } entry_type;

   // Lookup results gathered across the row.
   typedef struct packed {
      logic                  found;
      logic [IDX_WIDTH-1:0]  hit_pos;
      logic [DATA_WIDTH-1:0] hit_data;
      logic [KEY_WIDTH-1:0]  tail_key;
   } lookup_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

endpackage

`default_nettype wire

// File: rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU cache cell
// Holds one entry, compares it against the lookup key and takes its
// neighbour's entry when the row shifts across its position.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [lkv_pkg::IDX_WIDTH-1:0]    cell_index,
   input  wire lkv_pkg::shift_cmd_type           shift_cmd,
   input  wire lkv_pkg::entry_type               prev_entry,
   input  wire lkv_pkg::entry_type               next_entry,
   input  wire logic [lkv_pkg::KEY_WIDTH-1:0]    lookup_key,
   output lkv_pkg::entry_type                    entry,
   output logic                                  match
);

   logic                           valid_ff;
   logic [lkv_pkg::KEY_WIDTH-1:0]  key_ff;
   logic [lkv_pkg::DATA_WIDTH-1:0] data_ff;
   lkv_pkg::entry_type             entry_in;

   // Select the next content: hold, or take from the more or less recent side.
   always_comb begin
      entry_in = entry;
      case (shift_cmd.mode)
         lkv_pkg::SHIFT_DOWN: begin
            if (cell_index <= shift_cmd.pos) entry_in = prev_entry;
         end
         lkv_pkg::SHIFT_UP: begin
            if (cell_index >= shift_cmd.pos) entry_in = next_entry;
         end
         default: begin
            entry_in = entry;
         end
      endcase
   end

   // The valid mark is cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
   end

   // Key and data are meaningful only while the entry is valid.
   always_ff @(posedge clock) begin
      key_ff  <= entry_in.key;
      data_ff <= entry_in.data;
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.data  = data_ff;
   assign match       = valid_ff && (key_ff == lookup_key);

endmodule

`default_nettype wire

// File: rtl/lkv_row.sv
// ----------------------------------------------------------------------------
// LRU cache cell row
// A chain of cells ordered by recency, cell zero most recent, with the
// gathering of hit position, hit data and least recent key across the row.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_row (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lkv_pkg::shift_cmd_type        shift_cmd,
   input  wire lkv_pkg::entry_type            head_entry,
   input  wire logic [lkv_pkg::KEY_WIDTH-1:0] lookup_key,
   input  wire logic [lkv_pkg::IDX_WIDTH-1:0] tail_pos,
   output lkv_pkg::lookup_type                lookup
);

   lkv_pkg::entry_type            cell_entry [lkv_pkg::CAPACITY];
   lkv_pkg::entry_type            prev_entry [lkv_pkg::CAPACITY];
   lkv_pkg::entry_type            next_entry [lkv_pkg::CAPACITY];
   logic [lkv_pkg::CAPACITY-1:0]  cell_match;

   // Each cell is wired to its neighbours; the ends see the new entry and an
   // empty entry.
   for (genvar i = 0; i < lkv_pkg::CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_entry[i] = head_entry;
      end else begin : g_prev
         assign prev_entry[i] = cell_entry[i-1];
      end
      if (i == lkv_pkg::CAPACITY - 1) begin : g_tail
         assign next_entry[i] = '0;
      end else begin : g_next
         assign next_entry[i] = cell_entry[i+1];
      end

      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (lkv_pkg::IDX_WIDTH'(i)),
         .shift_cmd  (shift_cmd),
         .prev_entry (prev_entry[i]),
         .next_entry (next_entry[i]),
         .lookup_key (lookup_key),
         .entry      (cell_entry[i]),
         .match      (cell_match[i])
      );
   end

   // Keys are unique among valid entries, so at most one cell matches and the
   // results can be gathered with OR trees.
   always_comb begin
      lookup = '0;
      lookup.found = |cell_match;
      for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
         if (cell_match[i]) begin
            lookup.hit_pos  = lookup.hit_pos | lkv_pkg::IDX_WIDTH'(i);
            lookup.hit_data = lookup.hit_data | cell_entry[i].data;
         end
         if (lkv_pkg::IDX_WIDTH'(i) == tail_pos) begin
            lookup.tail_key = lookup.tail_key | cell_entry[i].key;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high through a lookup state, in which every cell compares its key at once,
// and an update state, in which the row shifts to reorder by recency, and no
// new transaction is taken before that sequence ends. The result is presented
// for exactly one cycle, marked by rsp_valid, in the cycle after the shift;
// the receiver cannot stall it, so it must take every result as it appears.
// The capacity register is written through csr_valid/csr_ready, always ready;
// the user must write it only while the cache is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [lkv_pkg::FUNC_WIDTH-1:0]    req_func,
   input  wire logic [lkv_pkg::FIELD_WIDTH-1:0]   req_key,
   input  wire logic [lkv_pkg::FIELD_WIDTH-1:0]   req_write_data,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic [lkv_pkg::FIELD_WIDTH-1:0]        rsp_read_data,
   output logic                                   rsp_evicted,
   output logic [lkv_pkg::FIELD_WIDTH-1:0]        rsp_victim_key,
   output logic [lkv_pkg::OCC_WIDTH-1:0]          rsp_occupancy,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lkv_pkg::CAP_WIDTH-1:0]     csr_wdata
);

   lkv_pkg::state_type              state_ff, state_in;
   logic [lkv_pkg::FUNC_WIDTH-1:0]  func_ff;
   logic [lkv_pkg::KEY_WIDTH-1:0]   key_ff;
   logic [lkv_pkg::DATA_WIDTH-1:0]  wdata_ff;
   lkv_pkg::lookup_type             lookup_ff, lookup_row;
   logic [lkv_pkg::CNT_WIDTH-1:0]   count_ff, count_in;
   logic [lkv_pkg::CAP_WIDTH-1:0]   capacity_ff;
   logic [lkv_pkg::CNT_WIDTH-1:0]   limit;
   logic [lkv_pkg::IDX_WIDTH-1:0]   tail_pos;
   logic                            accept;
   lkv_pkg::shift_cmd_type          shift_cmd;
   lkv_pkg::entry_type              head_entry;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [lkv_pkg::FIELD_WIDTH-1:0] rsp_read_data_ff, rsp_read_data_in;
   logic                            rsp_evicted_ff, rsp_evicted_in;
   logic [lkv_pkg::FIELD_WIDTH-1:0] rsp_victim_key_ff, rsp_victim_key_in;
   logic [lkv_pkg::OCC_WIDTH-1:0]   rsp_occupancy_ff, rsp_occupancy_in;

   // Effective capacity: zero acts as one, anything above the store as full.
   always_comb begin
      if (capacity_ff == '0) begin
         limit = lkv_pkg::CNT_WIDTH'(1);
      end else if (int'(capacity_ff) > lkv_pkg::CAPACITY) begin
         limit = lkv_pkg::CNT_WIDTH'(lkv_pkg::CAPACITY);
      end else begin
         limit = lkv_pkg::CNT_WIDTH'(capacity_ff);
      end
   end

   // Valid entries occupy the front of the row, so the least recent one sits
   // at the last occupied position.
   assign tail_pos = lkv_pkg::IDX_WIDTH'(count_ff - 1'b1);

   lkv_row u_row (
      .clock      (clock),
      .reset      (reset),
      .shift_cmd  (shift_cmd),
      .head_entry (head_entry),
      .lookup_key (key_ff),
      .tail_pos   (tail_pos),
      .lookup     (lookup_row)
   );

   // Sequencer: next state, row command and result of the update cycle.
   always_comb begin
      state_in           = state_ff;
      accept             = 1'b0;
      count_in           = count_ff;
      shift_cmd.mode     = lkv_pkg::SHIFT_NONE;
      shift_cmd.pos      = lookup_ff.hit_pos;
      head_entry.valid   = 1'b1;
      head_entry.key     = key_ff;
      head_entry.data    = wdata_ff;
      rsp_valid_in       = 1'b0;
      rsp_found_in       = 1'b0;
      rsp_read_data_in   = '0;
      rsp_evicted_in     = 1'b0;
      rsp_victim_key_in  = '0;
      case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (start) begin
               accept   = 1'b1;
               state_in = lkv_pkg::ST_LOOKUP;
            end
         end
         lkv_pkg::ST_LOOKUP: begin
            state_in = lkv_pkg::ST_UPDATE;
         end
         lkv_pkg::ST_UPDATE: begin
            state_in     = lkv_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            case (func_ff)
               lkv_pkg::FUNC_GET: begin
                  rsp_found_in = lookup_ff.found;
                  if (lookup_ff.found) begin
                     // Move the hit entry to the front unchanged.
                     shift_cmd.mode   = lkv_pkg::SHIFT_DOWN;
                     head_entry.data  = lookup_ff.hit_data;
                     rsp_read_data_in = lkv_pkg::FIELD_WIDTH'(lookup_ff.hit_data);
                  end
               end
               lkv_pkg::FUNC_PUT: begin
                  rsp_found_in   = lookup_ff.found;
                  shift_cmd.mode = lkv_pkg::SHIFT_DOWN;
                  if (!lookup_ff.found) begin
                     if (count_ff >= limit) begin
                        // Full: the least recent entry drops off the end.
                        shift_cmd.pos     = tail_pos;
                        rsp_evicted_in    = 1'b1;
                        rsp_victim_key_in = lkv_pkg::FIELD_WIDTH'(lookup_ff.tail_key);
                     end else begin
                        // Room left: the row grows by one position.
                        shift_cmd.pos = lkv_pkg::IDX_WIDTH'(count_ff);
                        count_in      = count_ff + 1'b1;
                     end
                  end
               end
               lkv_pkg::FUNC_REMOVE: begin
                  rsp_found_in = lookup_ff.found;
                  if (lookup_ff.found) begin
                     // Close the gap by pulling less recent entries forward.
                     shift_cmd.mode = lkv_pkg::SHIFT_UP;
                     count_in       = count_ff - 1'b1;
                  end
               end
               default: begin
                  rsp_found_in = 1'b0;
               end
            endcase
         end
         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase
      rsp_occupancy_in = lkv_pkg::OCC_WIDTH'(count_in);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= lkv_pkg::CAP_WIDTH'(lkv_pkg::CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) capacity_ff <= csr_wdata;
      end
   end

   // Transaction fields, lookup results and result fields.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         key_ff   <= lkv_pkg::KEY_WIDTH'(req_key);
         wdata_ff <= lkv_pkg::DATA_WIDTH'(req_write_data);
      end
      if (state_ff == lkv_pkg::ST_LOOKUP) lookup_ff <= lookup_row;
      if (rsp_valid_in) begin
         rsp_found_ff      <= rsp_found_in;
         rsp_read_data_ff  <= rsp_read_data_in;
         rsp_evicted_ff    <= rsp_evicted_in;
         rsp_victim_key_ff <= rsp_victim_key_in;
         rsp_occupancy_ff  <= rsp_occupancy_in;
      end
   end

   assign busy           = (state_ff != lkv_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_victim_key = rsp_victim_key_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;

   // Checks on the sequencing and on the entry count.
   `LKV_ASSERT_NXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   `LKV_ASSERT_NXT(a_result_after_update, clock, reset, state_ff == lkv_pkg::ST_UPDATE, rsp_valid)
   `LKV_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `LKV_ASSERT_IMP(a_evict_on_miss, clock, reset, rsp_valid && rsp_evicted, !rsp_found && (count_ff != '0))

endmodule

`default_nettype wire

// File: verif/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get, put, remove and spare transactions through the command port,
// predicts every result with a cycle-free model of the cache, and checks each
// result field by field while the capacity register is stepped through its range.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_key_value_cache_tb;

   import lkv_pkg::*;

   localparam real HALF_PERIOD    = 6.0;
   localparam int  SETTLE_CYCLES  = 6;
   localparam int  WATCHDOG_LIMIT = 1000;
   localparam int  PHASE_ITEMS    = 250;

   // The fourth operation code has no meaning and must leave the cache alone.
   localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE = 2'd3;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]  func;
      logic [FIELD_WIDTH-1:0] key;
      logic [FIELD_WIDTH-1:0] write_data;
   } cache_request_type;

   typedef struct packed {
      logic                   found;
      logic [FIELD_WIDTH-1:0] read_data;
      logic                   evicted;
      logic [FIELD_WIDTH-1:0] victim_key;
      logic [OCC_WIDTH-1:0]   occupancy;
   } cache_result_type;

   // Block ports; every input has a known value from time zero.
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   start          = 1'b0;
   logic                   busy;
   logic [FUNC_WIDTH-1:0]  req_func       = '0;
   logic [FIELD_WIDTH-1:0] req_key        = '0;
   logic [FIELD_WIDTH-1:0] req_write_data = '0;
   logic                   rsp_valid;
   logic                   rsp_found;
   logic [FIELD_WIDTH-1:0] rsp_read_data;
   logic                   rsp_evicted;
   logic [FIELD_WIDTH-1:0] rsp_victim_key;
   logic [OCC_WIDTH-1:0]   rsp_occupancy;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CAP_WIDTH-1:0]   csr_wdata      = '0;

   // Stimulus and scoreboard state.
   cache_request_type pending_ops[$];
   cache_result_type  predicted_results[$];
   int             items_queued     = 0;
   int             items_accepted   = 0;
   int             results_seen     = 0;
   int             csr_writes       = 0;
   int             error_count      = 0;
   int             hits_predicted   = 0;
   int             evictions_predicted = 0;
   int             idle_cycles      = 0;
   logic           req_taken        = 1'b0;
   int             sender_max_gap   = 3;

   // Sender burst state, private to the driver.
   int             burst_left       = 0;
   int             gap_left         = 0;
   bit             drain_hold       = 1'b1;

   // Shadow copy of the cache contents and its recency order.
   logic                  cached_valid [CAPACITY];
   logic [KEY_WIDTH-1:0]  cached_key   [CAPACITY];
   logic [DATA_WIDTH-1:0] cached_data  [CAPACITY];
   int                    cached_rank  [CAPACITY];
   int                    cached_count;
   logic [CAP_WIDTH-1:0]  capacity_reg;

   lru_key_value_cache dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_read_data   (rsp_read_data),
      .rsp_evicted     (rsp_evicted),
      .rsp_victim_key  (rsp_victim_key),
      .rsp_occupancy   (rsp_occupancy),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Empties the shadow cache and restores the capacity register.
   function automatic void clear_shadow_cache();
      for (int i = 0; i < CAPACITY; i++) begin
         cached_valid[i] = 1'b0;
         cached_key[i]   = '0;
         cached_data[i]  = '0;
         cached_rank[i]  = 0;
      end
      cached_count = 0;
      capacity_reg = CAP_WIDTH'(CAP_RESET);
   endfunction

   // Makes a slot the most recent; valid entries more recent than its old rank
   // move one place down.
   function automatic void move_to_front(int slot, int old_rank);
      for (int i = 0; i < CAPACITY; i++) begin
         if (i != slot && cached_valid[i] && cached_rank[i] < old_rank) begin
            cached_rank[i]++;
         end
      end
      cached_rank[slot] = 0;
   endfunction

   // Applies one transaction to the shadow cache and returns its result.
   function automatic cache_result_type predict_result(cache_request_type op);
      cache_result_type res;
      int hit_slot;
      int victim;
      int worst;
      int limit;
      int free_slot;
      int old_rank;
      res      = '0;
      hit_slot = -1;
      victim   = -1;
      worst    = 0;
      free_slot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit_slot < 0 && cached_valid[i] && cached_key[i] == op.key[KEY_WIDTH-1:0]) begin
            hit_slot = i;
         end
      end
      // A zero capacity behaves as one, anything above the store as the store.
      if (capacity_reg == 0) begin
         limit = 1;
      end else if (capacity_reg > CAPACITY) begin
         limit = CAPACITY;
      end else begin
         limit = capacity_reg;
      end
      if (op.func != FUNC_SPARE) begin
         res.found = (hit_slot >= 0);
      end
      case (op.func)
         FUNC_GET: begin
            if (hit_slot >= 0) begin
               res.read_data = cached_data[hit_slot];
               move_to_front(hit_slot, cached_rank[hit_slot]);
            end
         end
         FUNC_PUT: begin
            if (hit_slot >= 0) begin
               cached_data[hit_slot] = op.write_data[DATA_WIDTH-1:0];
               move_to_front(hit_slot, cached_rank[hit_slot]);
            end else if (cached_count >= limit) begin
               // Full, or capacity lowered below the count: one eviction only.
               for (int i = 0; i < CAPACITY; i++) begin
                  if (cached_valid[i] && (victim < 0 || cached_rank[i] >= worst)) begin
                     victim = i;
                     worst  = cached_rank[i];
                  end
               end
               if (victim >= 0) begin
                  res.evicted         = 1'b1;
                  res.victim_key      = cached_key[victim];
                  cached_key[victim]  = op.key[KEY_WIDTH-1:0];
                  cached_data[victim] = op.write_data[DATA_WIDTH-1:0];
                  move_to_front(victim, worst);
               end
            end else begin
               for (int i = CAPACITY - 1; i >= 0; i--) begin
                  if (!cached_valid[i]) begin
                     free_slot = i;
                  end
               end
               if (free_slot >= 0) begin
                  move_to_front(free_slot, CAPACITY);
                  cached_valid[free_slot] = 1'b1;
                  cached_key[free_slot]   = op.key[KEY_WIDTH-1:0];
                  cached_data[free_slot]  = op.write_data[DATA_WIDTH-1:0];
                  cached_count++;
               end
            end
         end
         FUNC_REMOVE: begin
            if (hit_slot >= 0) begin
               old_rank = cached_rank[hit_slot];
               for (int i = 0; i < CAPACITY; i++) begin
                  if (cached_valid[i] && cached_rank[i] > old_rank) begin
                     cached_rank[i]--;
                  end
               end
               cached_valid[hit_slot] = 1'b0;
               cached_rank[hit_slot]  = 0;
               if (cached_count > 0) begin
                  cached_count--;
               end
            end
         end
         default: begin
         end
      endcase
      res.occupancy = OCC_WIDTH'(cached_count);
      return res;
   endfunction

   // Driver: presents queued transactions in bursts with random gaps, holding
   // each one until the cache takes it.
   always @(negedge clock) begin
      cache_request_type next_op;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // Transaction still waiting for the cache to go idle.
      end else if (gap_left > 0) begin
         start    <= 1'b0;
         gap_left  = gap_left - 1;
      end else if (drain_hold && items_accepted != results_seen) begin
         start <= 1'b0;
      end else if (pending_ops.size() == 0) begin
         start <= 1'b0;
      end else begin
         next_op         = pending_ops.pop_front();
         start          <= 1'b1;
         req_func       <= next_op.func;
         req_key        <= next_op.key;
         req_write_data <= next_op.write_data;
         drain_hold      = 1'b0;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
            drain_hold = ($urandom_range(0, 9) == 0);
         end else begin
            burst_left = burst_left - 1;
         end
      end
   end

   // Monitor: follows the shadow cache on every accepted transaction and
   // register write, and checks each result against the oldest prediction.
   always @(posedge clock) begin
      cache_request_type seen_op;
      cache_result_type  want;
      if (reset) begin
         clear_shadow_cache();
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (csr_valid && csr_ready) begin
            capacity_reg = csr_wdata;
            csr_writes  <= csr_writes + 1;
         end
         if (rsp_valid) begin
            results_seen <= results_seen + 1;
            if (predicted_results.size() == 0) begin
               $error("result with no transaction outstanding");
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  error_count++;
               end
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  error_count++;
               end
               if (rsp_evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d", want.evicted, rsp_evicted);
                  error_count++;
               end
               if (rsp_victim_key !== want.victim_key) begin
                  $error("victim_key: expected %h, got %h",
                         want.victim_key, rsp_victim_key);
                  error_count++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            seen_op.func       = req_func;
            seen_op.key        = req_key;
            seen_op.write_data = req_write_data;
            want               = predict_result(seen_op);
            if (want.found && seen_op.func == FUNC_GET) begin
               hits_predicted++;
            end
            if (want.evicted) begin
               evictions_predicted++;
            end
            predicted_results.push_back(want);
            items_accepted <= items_accepted + 1;
         end
      end
   end

   // Watchdog: ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired: %0d of %0d results seen", results_seen, items_queued);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_op(input logic [FUNC_WIDTH-1:0] func,
                           input logic [FIELD_WIDTH-1:0] key,
                           input logic [FIELD_WIDTH-1:0] write_data);
      cache_request_type op;
      op.func       = func;
      op.key        = key;
      op.write_data = write_data;
      pending_ops.push_back(op);
      items_queued++;
   endtask

   // Waits until every queued transaction has produced its result and the
   // cache has had time to settle.
   task automatic drain_cache();
      @(negedge clock);
      while (results_seen != items_queued) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the capacity register while the cache is idle.
   task automatic set_capacity(input logic [CAP_WIDTH-1:0] value);
      int writes_before;
      drain_cache();
      writes_before = csr_writes;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(negedge clock);
      while (csr_writes == writes_before) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Queues one phase of random transactions over a small key set sized to
   // the capacity, so that hits, misses and evictions all occur often.
   task automatic fill_random_phase(input logic [CAP_WIDTH-1:0] cap_value);
      int                     key_count;
      int                     pick;
      logic [FIELD_WIDTH-1:0] key_set [$];
      logic [FIELD_WIDTH-1:0] key;
      logic [FUNC_WIDTH-1:0]  func;
      if (cap_value == 0) begin
         key_count = 1;
      end else if (cap_value > CAPACITY) begin
         key_count = CAPACITY;
      end else begin
         key_count = cap_value;
      end
      key_count = key_count + $urandom_range(1, 6);
      for (int i = 0; i < key_count; i++) begin
         key_set.push_back($urandom);
      end
      if ($urandom_range(0, 2) == 0) begin
         key_set[0] = '0;
      end
      if ($urandom_range(0, 2) == 0) begin
         key_set[1] = '1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            func = FUNC_GET;
         end else if (pick < 75) begin
            func = FUNC_PUT;
         end else if (pick < 95) begin
            func = FUNC_REMOVE;
         end else begin
            func = FUNC_SPARE;
         end
         if ($urandom_range(0, 9) == 0) begin
            key = $urandom;
         end else begin
            key = key_set[$urandom_range(0, key_count - 1)];
         end
         queue_op(func, key, $urandom);
      end
   endtask

   // Stimulus sequencing.
   initial begin
      int                   leftover;
      int                   phase_caps [8];
      logic [CAP_WIDTH-1:0] cap_value;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty cache, key and data extremes, replace, spare code,
      // remove hit and miss, all at the reset capacity.
      @(posedge clock);
      queue_op(FUNC_GET,    32'h0000_0000, 32'h0000_0000);
      queue_op(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(FUNC_PUT,    32'h0000_0000, 32'h0000_0000);
      queue_op(FUNC_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(FUNC_PUT,    32'h1234_5678, 32'h9ABC_DEF0);
      queue_op(FUNC_GET,    32'h0000_0000, 32'hFFFF_FFFF);
      queue_op(FUNC_GET,    32'hFFFF_FFFF, 32'h0000_0000);
      queue_op(FUNC_PUT,    32'h0000_0000, 32'h5A5A_A5A5);
      queue_op(FUNC_SPARE,  32'h1234_5678, 32'hFFFF_FFFF);
      queue_op(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_op(FUNC_GET,    32'hFFFF_FFFF, 32'h0000_0000);
      queue_op(FUNC_PUT,    32'hA5A5_A5A5, 32'h0F0F_0F0F);

      // Capacity lowered below the count: new keys evict one entry each.
      set_capacity(5'd1);
      @(posedge clock);
      queue_op(FUNC_PUT,    32'h0000_0001, 32'h1111_1111);
      queue_op(FUNC_PUT,    32'h0000_0002, 32'h2222_2222);
      queue_op(FUNC_GET,    32'h0000_0002, 32'h0000_0000);
      queue_op(FUNC_REMOVE, 32'h0000_0002, 32'h0000_0000);
      queue_op(FUNC_PUT,    32'h0000_0003, 32'h3333_3333);

      // A zero capacity acts as one.
      set_capacity(5'd0);
      @(posedge clock);
      queue_op(FUNC_PUT,    32'h8000_0000, 32'h8000_0000);
      queue_op(FUNC_PUT,    32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_op(FUNC_GET,    32'h7FFF_FFFF, 32'h0000_0000);

      // Random phases across the capacity range, extremes included, with and
      // without sender gaps.
      phase_caps = '{31, 3, 16, 0, 9, 1, 12, 0};
      phase_caps[7] = $urandom_range(0, 31);
      for (int p = 0; p < 8; p++) begin
         cap_value = CAP_WIDTH'(phase_caps[p]);
         set_capacity(cap_value);
         @(posedge clock);
         sender_max_gap = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 6 : 2);
         fill_random_phase(cap_value);
      end

      drain_cache();
      leftover = predicted_results.size();
      if (leftover != 0) begin
         $error("%0d predicted results never arrived", leftover);
      end
      $display("Covered %0d transactions (%0d get hits, %0d evictions), %0d capacity writes.",
               items_accepted, hits_predicted, evictions_predicted, csr_writes);
      $display("Sender ran with and without gaps and drained fully before each write.");
      if (error_count == 0 && leftover == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
